// File: rtl/qte_pkg.sv
// Shared constants and helpers for the quaternion to Euler angle converter.
`default_nettype none

package qte_pkg;

  // Width of the CORDIC angle accumulator; 2^31 stands for pi.
  localparam int ANG_W = 34;
  localparam int ANG_PI_BIT = 31;

  // Micro-rotation angles atan(2^-i), rounded to nearest, 2^31 = pi.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Table lookup that reads as zero past the end of the table.
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] val;
    val = '0;
    if (idx < 32) begin
      val = ATAN_TAB[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/qte_stream_if.sv
// Valid/ready stream interfaces for quaternion input and Euler angle output.
`default_nettype none

interface qte_in_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] quat_x;
  logic signed [DW-1:0] quat_y;
  logic signed [DW-1:0] quat_z;
  logic signed [DW-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_out_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] roll_angle;
  logic signed [DW-1:0] pitch_angle;
  logic signed [DW-1:0] yaw_angle;
  logic                 pitch_clamped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/qte_quad.sv
// Front end: component products, quadratic forms and the pitch radicand.
`default_nettype none

module qte_quad #(
  parameter int DW = 16,
  parameter int PS = 0,
  parameter int PW = 32,
  parameter int QW = 35,
  parameter int F  = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] qx,
  input  logic signed [DW-1:0] qy,
  input  logic signed [DW-1:0] qz,
  input  logic signed [DW-1:0] qw,
  output logic                 valid_o,
  output logic signed [QW-1:0] sr_o,
  output logic signed [QW-1:0] cr_o,
  output logic signed [QW-1:0] sy_o,
  output logic signed [QW-1:0] cy_o,
  output logic signed [QW-1:0] sp_o,
  output logic                 clamp_o,
  output logic [2*F:0]         rem_o
);

  localparam logic signed [QW-1:0] ONE = QW'(1) <<< F;

  logic signed [2*DW-1:0] m_wx, m_yz, m_xx, m_yy, m_wz, m_xy, m_zz, m_wy, m_zx;
  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r;
  logic signed [PW-1:0] p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  logic                 v_a_r, v_b_r, v_c_r;
  logic signed [QW-1:0] sr_nxt, cr_nxt, sy_nxt, cy_nxt, sp_nxt;
  logic signed [QW-1:0] sr_b_r, cr_b_r, sy_b_r, cy_b_r, sp_b_r;
  logic                 clamp_b_r;
  logic signed [QW-1:0] mag_b;
  logic [2*F-1:0]       sq_b;
  logic signed [QW-1:0] sr_c_r, cr_c_r, sy_c_r, cy_c_r, sp_c_r;
  logic                 clamp_c_r;
  logic [2*F:0]         rem_c_r;

  // Full products of the components.
  assign m_wx = qw * qx;
  assign m_yz = qy * qz;
  assign m_xx = qx * qx;
  assign m_yy = qy * qy;
  assign m_wz = qw * qz;
  assign m_xy = qx * qy;
  assign m_zz = qz * qz;
  assign m_wy = qw * qy;
  assign m_zx = qz * qx;

  // Quadratic forms from the registered products.
  always_comb begin
    sr_nxt = (QW'(p_wx_r) + QW'(p_yz_r)) <<< 1;
    cr_nxt = ONE - ((QW'(p_xx_r) + QW'(p_yy_r)) <<< 1);
    sy_nxt = (QW'(p_wz_r) + QW'(p_xy_r)) <<< 1;
    cy_nxt = ONE - ((QW'(p_yy_r) + QW'(p_zz_r)) <<< 1);
    sp_nxt = (QW'(p_wy_r) - QW'(p_zx_r)) <<< 1;
  end

  // Square of the pitch sine; only its low F bits matter when not clamped.
  assign mag_b = sp_b_r[QW-1] ? -sp_b_r : sp_b_r;
  assign sq_b  = mag_b[F-1:0] * mag_b[F-1:0];

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else if (en) begin
      v_a_r <= valid_i;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r    <= $signed(m_wx[2*DW-1:PS]);
      p_yz_r    <= $signed(m_yz[2*DW-1:PS]);
      p_xx_r    <= $signed(m_xx[2*DW-1:PS]);
      p_yy_r    <= $signed(m_yy[2*DW-1:PS]);
      p_wz_r    <= $signed(m_wz[2*DW-1:PS]);
      p_xy_r    <= $signed(m_xy[2*DW-1:PS]);
      p_zz_r    <= $signed(m_zz[2*DW-1:PS]);
      p_wy_r    <= $signed(m_wy[2*DW-1:PS]);
      p_zx_r    <= $signed(m_zx[2*DW-1:PS]);
      sr_b_r    <= sr_nxt;
      cr_b_r    <= cr_nxt;
      sy_b_r    <= sy_nxt;
      cy_b_r    <= cy_nxt;
      sp_b_r    <= sp_nxt;
      clamp_b_r <= ((sp_nxt[QW-1] ? -sp_nxt : sp_nxt) >= ONE);
      sr_c_r    <= sr_b_r;
      cr_c_r    <= cr_b_r;
      sy_c_r    <= sy_b_r;
      cy_c_r    <= cy_b_r;
      sp_c_r    <= sp_b_r;
      clamp_c_r <= clamp_b_r;
      rem_c_r   <= {1'b1, {(2*F){1'b0}}} - {1'b0, sq_b};
    end
  end

  assign valid_o = v_c_r;
  assign sr_o    = sr_c_r;
  assign cr_o    = cr_c_r;
  assign sy_o    = sy_c_r;
  assign cy_o    = cy_c_r;
  assign sp_o    = sp_c_r;
  assign clamp_o = clamp_c_r;
  assign rem_o   = rem_c_r;

endmodule

`default_nettype wire

// File: rtl/qte_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per stage.
`default_nettype none

module qte_sqrt_cell #(
  parameter int F  = 28,
  parameter int B  = 27,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_i,
  input  logic [2*F:0]  rem_i,
  input  logic [F:0]    root_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [2*F:0]  rem_o,
  output logic [F:0]    root_o,
  output logic [SW-1:0] side_o
);

  logic [2*F:0]  trial;
  logic          take;
  logic          valid_r;
  logic [2*F:0]  rem_r, rem_nxt;
  logic [F:0]    root_r, root_nxt;
  logic [SW-1:0] side_r;

  // Try setting bit B: (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
  always_comb begin
    trial    = ((2*F+1)'(root_i) << (B + 1)) | ((2*F+1)'(1) << (2 * B));
    take     = (rem_i >= trial);
    rem_nxt  = take ? (rem_i - trial) : rem_i;
    root_nxt = root_i | ((F+1)'(take) << B);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// File: rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation applied to the three angle lanes.
`default_nettype none

module qte_cordic_cell #(
  parameter int XW = 38,
  parameter int I  = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic signed [XW-1:0]            x_i    [3],
  input  logic signed [XW-1:0]            y_i    [3],
  input  logic signed [qte_pkg::ANG_W-1:0] z_i   [3],
  input  logic [2:0]                      zero_i,
  input  logic [1:0]                      side_i,
  output logic                            valid_o,
  output logic signed [XW-1:0]            x_o    [3],
  output logic signed [XW-1:0]            y_o    [3],
  output logic signed [qte_pkg::ANG_W-1:0] z_o   [3],
  output logic [2:0]                      zero_o,
  output logic [1:0]                      side_o
);

  localparam logic signed [qte_pkg::ANG_W-1:0] STEP =
    $signed({{(qte_pkg::ANG_W-32){1'b0}}, qte_pkg::atan_entry(I)});

  logic signed [XW-1:0]             x_nxt [3];
  logic signed [XW-1:0]             y_nxt [3];
  logic signed [qte_pkg::ANG_W-1:0] z_nxt [3];
  logic signed [XW-1:0]             x_r   [3];
  logic signed [XW-1:0]             y_r   [3];
  logic signed [qte_pkg::ANG_W-1:0] z_r   [3];
  logic [2:0]                       zero_r;
  logic [1:0]                       side_r;
  logic                             valid_r;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!y_i[l][XW-1]) begin
        x_nxt[l] = x_i[l] + (y_i[l] >>> I);
        y_nxt[l] = y_i[l] - (x_i[l] >>> I);
        z_nxt[l] = z_i[l] + STEP;
      end else begin
        x_nxt[l] = x_i[l] - (y_i[l] >>> I);
        y_nxt[l] = y_i[l] + (x_i[l] >>> I);
        z_nxt[l] = z_i[l] - STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign zero_o  = zero_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// File: rtl/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to ZYX Euler angle converter.
//
//   Channel  Direction  Payload
//   in_s     sink       quat_x, quat_y, quat_z, quat_w (signed Q1.14)
//   out_s    source     roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One quaternion is taken per cycle unless the output stalls; F is the
// fraction width of the quadratic forms (28 at the default width). The square
// root chain has one cell per root bit (F + 1 bits) and the CORDIC chain one
// cell per micro-rotation. The whole pipeline advances only while the output
// register is empty or being taken, so a stalled output freezes every
// stage. Reset clears the valid bits only.
`default_nettype none

module quaternion_to_euler_angles_top #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_s,
  qte_out_if.source out_s
);

  localparam int DW  = DATA_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int PS  = (DW > 16) ? (2 * DW - 32) : 0;
  localparam int F   = (DW > 16) ? 28 : (2 * DW - 4);
  localparam int PW  = 2 * DW - PS;
  localparam int QW  = PW + 3;
  localparam int XW  = QW + 3;
  localparam int AW  = qte_pkg::ANG_W;
  localparam int SH  = 32 - DW;
  localparam int SW  = 5 * QW + 1;
  localparam logic signed [AW-1:0] ANG_PI   = AW'(1) <<< qte_pkg::ANG_PI_BIT;
  localparam logic signed [AW-1:0] HALF_LSB = (AW'(1) <<< SH) >>> 1;
  localparam logic signed [DW-1:0] QUARTER  = DW'(1) <<< (DW - 2);

  logic adv;

  // Front end outputs.
  logic                 q_v;
  logic signed [QW-1:0] q_sr, q_cr, q_sy, q_cy, q_sp;
  logic                 q_clamp;
  logic [2*F:0]         q_rem;

  // Square root chain taps.
  logic                 sq_v    [F+2];
  logic [2*F:0]         sq_rem  [F+2];
  logic [F:0]           sq_root [F+2];
  logic [SW-1:0]        sq_side [F+2];

  // Lane setup ahead of the CORDIC chain.
  logic signed [QW-1:0] ln_y [3];
  logic signed [QW-1:0] ln_x [3];
  logic signed [XW-1:0] pr_x_nxt [3];
  logic signed [XW-1:0] pr_y_nxt [3];
  logic signed [AW-1:0] pr_z_nxt [3];
  logic [2:0]           pr_zero_nxt;
  logic                 pr_v_r;
  logic signed [XW-1:0] pr_x_r [3];
  logic signed [XW-1:0] pr_y_r [3];
  logic signed [AW-1:0] pr_z_r [3];
  logic [2:0]           pr_zero_r;
  logic [1:0]           pr_side_r;

  // CORDIC chain taps.
  logic                 cd_v    [N+1];
  logic signed [XW-1:0] cd_x    [N+1][3];
  logic signed [XW-1:0] cd_y    [N+1][3];
  logic signed [AW-1:0] cd_z    [N+1][3];
  logic [2:0]           cd_zero [N+1];
  logic [1:0]           cd_side [N+1];

  // Output stage.
  logic signed [AW-1:0] rnd [3];
  logic signed [DW-1:0] ang [3];
  logic signed [DW-1:0] pitch_nxt;
  logic                 out_valid_r;
  logic signed [DW-1:0] roll_r, pitch_r, yaw_r;
  logic                 clamp_r;

  // Every stage moves when the output register can take a new transaction.
  assign adv        = !out_valid_r || out_s.ready;
  assign in_s.ready = adv;

  qte_quad #(.DW(DW), .PS(PS), .PW(PW), .QW(QW), .F(F)) u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_s.valid),
    .qx      (in_s.quat_x),
    .qy      (in_s.quat_y),
    .qz      (in_s.quat_z),
    .qw      (in_s.quat_w),
    .valid_o (q_v),
    .sr_o    (q_sr),
    .cr_o    (q_cr),
    .sy_o    (q_sy),
    .cy_o    (q_cy),
    .sp_o    (q_sp),
    .clamp_o (q_clamp),
    .rem_o   (q_rem)
  );

  // Square root of 1 - s^2, one root bit per cell, MSB first. The root
  // reaches exactly 1.0 when s is zero, so it carries F + 1 bits.
  assign sq_v[0]    = q_v;
  assign sq_rem[0]  = q_rem;
  assign sq_root[0] = '0;
  assign sq_side[0] = {q_sr, q_cr, q_sy, q_cy, q_sp, q_clamp};

  for (genvar k = 0; k < F + 1; k++) begin : g_sqrt
    qte_sqrt_cell #(.F(F), .B(F - k), .SW(SW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sq_v[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_v[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // Lanes: roll, pitch, yaw. Negative abscissa turns the vector by pi.
  always_comb begin
    ln_y[0] = $signed(sq_side[F+1][5*QW:4*QW+1]);
    ln_x[0] = $signed(sq_side[F+1][4*QW:3*QW+1]);
    ln_y[2] = $signed(sq_side[F+1][3*QW:2*QW+1]);
    ln_x[2] = $signed(sq_side[F+1][2*QW:QW+1]);
    ln_y[1] = $signed(sq_side[F+1][QW:1]);
    ln_x[1] = $signed({{(QW-F-1){1'b0}}, sq_root[F+1]});
    for (int l = 0; l < 3; l++) begin
      pr_zero_nxt[l] = (ln_x[l] == '0) && (ln_y[l] == '0);
      if (ln_x[l][QW-1]) begin
        pr_x_nxt[l] = -XW'(ln_x[l]);
        pr_y_nxt[l] = -XW'(ln_y[l]);
        pr_z_nxt[l] = ln_y[l][QW-1] ? -ANG_PI : ANG_PI;
      end else begin
        pr_x_nxt[l] = XW'(ln_x[l]);
        pr_y_nxt[l] = XW'(ln_y[l]);
        pr_z_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (adv) begin
      pr_v_r <= sq_v[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_x_r    <= pr_x_nxt;
      pr_y_r    <= pr_y_nxt;
      pr_z_r    <= pr_z_nxt;
      pr_zero_r <= pr_zero_nxt;
      pr_side_r <= {sq_side[F+1][0], sq_side[F+1][QW]};
    end
  end

  // CORDIC chain, one micro-rotation per cell.
  assign cd_v[0]    = pr_v_r;
  assign cd_x[0]    = pr_x_r;
  assign cd_y[0]    = pr_y_r;
  assign cd_z[0]    = pr_z_r;
  assign cd_zero[0] = pr_zero_r;
  assign cd_side[0] = pr_side_r;

  for (genvar k = 0; k < N; k++) begin : g_cordic
    qte_cordic_cell #(.XW(XW), .I(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (cd_v[k]),
      .x_i     (cd_x[k]),
      .y_i     (cd_y[k]),
      .z_i     (cd_z[k]),
      .zero_i  (cd_zero[k]),
      .side_i  (cd_side[k]),
      .valid_o (cd_v[k+1]),
      .x_o     (cd_x[k+1]),
      .y_o     (cd_y[k+1]),
      .z_o     (cd_z[k+1]),
      .zero_o  (cd_zero[k+1]),
      .side_o  (cd_side[k+1])
    );
  end

  // Round half up to the output width; a zero vector gives angle zero.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = cd_z[N][l] + HALF_LSB;
      ang[l] = cd_zero[N][l] ? '0 : $signed(rnd[l][SH+DW-1:SH]);
    end
    if (cd_side[N][1]) begin
      pitch_nxt = cd_side[N][0] ? -QUARTER : QUARTER;
    end else begin
      pitch_nxt = ang[1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cd_v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= ang[0];
      pitch_r <= pitch_nxt;
      yaw_r   <= ang[2];
      clamp_r <= cd_side[N][1];
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.roll_angle    = roll_r;
  assign out_s.pitch_angle   = pitch_r;
  assign out_s.yaw_angle     = yaw_r;
  assign out_s.pitch_clamped = clamp_r;

endmodule

`default_nettype wire

// File: tb/sv/quaternion_to_euler_angles_top_tb.sv
// Randomized self-checking testbench for the quaternion to Euler angle converter.
`default_nettype none

module quaternion_to_euler_angles_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int NSTAGE = 16;
  localparam int FRAC = 28;
  localparam int LATENCY = FRAC + NSTAGE + 6;
  localparam int N_RANDOM = 1250;

  typedef struct packed {
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [DW-1:0] qz;
    logic signed [DW-1:0] qw;
  } quat_t;

  typedef struct packed {
    logic signed [DW-1:0] roll;
    logic signed [DW-1:0] pitch;
    logic signed [DW-1:0] yaw;
    logic                 clamped;
  } euler_t;

  logic clk;
  logic rst_n;
  logic failed;
  logic stim_done;
  logic hold_on;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];

  qte_in_if  #(.DW(DW)) in_ch ();
  qte_out_if #(.DW(DW)) out_ch ();

  quaternion_to_euler_angles_top #(
    .DATA_WIDTH(DW),
    .CORDIC_STAGES(NSTAGE)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_s(in_ch.sink),
    .out_s(out_ch.source)
  );

  // Vectoring CORDIC angle of (xv, yv) with 2^31 = pi.
  function automatic longint cordic_angle(input longint yv, input longint xv);
    longint acc;
    longint sx;
    longint sy;
    acc = 0;
    if (xv == 0 && yv == 0) begin
      return 0;
    end
    if (xv < 0) begin
      acc = (yv >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < NSTAGE; i++) begin
      sx = xv >>> i;
      sy = yv >>> i;
      if (yv >= 0) begin
        xv = xv + sy;
        yv = yv - sx;
        acc = acc + longint'(qte_pkg::ATAN_TAB[i]);
      end else begin
        xv = xv - sy;
        yv = yv + sx;
        acc = acc - longint'(qte_pkg::ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  // Round half up to the output angle width.
  function automatic logic [DW-1:0] round_angle(input longint acc);
    longint r;
    r = (acc + (64'sd1 <<< (32 - DW - 1))) >>> (32 - DW);
    return r[DW-1:0];
  endfunction

  // Floor of the integer square root.
  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Expected Euler angles for one quaternion.
  function automatic euler_t euler_of(input quat_t q);
    longint x;
    longint y;
    longint z;
    longint w;
    longint one;
    longint s_r;
    longint c_r;
    longint s_y;
    longint c_y;
    longint s_p;
    longint mag;
    longint unsigned rem;
    euler_t e;
    x = q.qx;
    y = q.qy;
    z = q.qz;
    w = q.qw;
    one = 64'sd1 <<< FRAC;
    s_r = 2 * (w * x + y * z);
    c_r = one - 2 * (x * x + y * y);
    s_y = 2 * (w * z + x * y);
    c_y = one - 2 * (y * y + z * z);
    s_p = 2 * (w * y - z * x);
    mag = (s_p < 0) ? -s_p : s_p;
    e.clamped = 1'b0;
    if (mag >= one) begin
      e.clamped = 1'b1;
      e.pitch = (s_p < 0) ? DW'(-(1 <<< (DW - 2))) : DW'(1 <<< (DW - 2));
    end else begin
      rem = longint'(one * one) - longint'(s_p * s_p);
      e.pitch = round_angle(cordic_angle(s_p, floor_sqrt(rem)));
    end
    e.roll = round_angle(cordic_angle(s_r, c_r));
    e.yaw = round_angle(cordic_angle(s_y, c_y));
    return e;
  endfunction

  function automatic logic signed [DW-1:0] rand_comp();
    return DW'($urandom);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset once, then the directed and random stimulus.
  initial begin
    quat_t q;
    int ang;
    real th;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: identity, extremes, pure axis turns, gimbal lock, zero.
    pending_quats.push_back('{0, 0, 0, 16384});
    pending_quats.push_back('{0, 0, 0, 0});
    pending_quats.push_back('{-32768, -32768, -32768, -32768});
    pending_quats.push_back('{32767, 32767, 32767, 32767});
    pending_quats.push_back('{32767, -32768, 32767, -32768});
    pending_quats.push_back('{16384, 0, 0, 0});
    pending_quats.push_back('{0, 16384, 0, 0});
    pending_quats.push_back('{0, 0, 16384, 0});
    pending_quats.push_back('{0, 0, 0, -16384});
    pending_quats.push_back('{0, 11585, 0, 11585});
    pending_quats.push_back('{0, -11585, 0, 11585});
    pending_quats.push_back('{8192, 8192, -8192, 8192});
    pending_quats.push_back('{-8192, 8192, 8192, 8192});
    pending_quats.push_back('{0, 0, 1, -16384});
    pending_quats.push_back('{0, 0, -1, -16384});
    pending_quats.push_back('{1, 0, 0, -16384});
    pending_quats.push_back('{-1, 0, 0, -16384});
    pending_quats.push_back('{0, 11584, 0, 11584});
    pending_quats.push_back('{0, 0, 0, 1});
    pending_quats.push_back('{0, 0, 0, -1});
    // Random: half with w within plus or minus 1 and x, y, z scaled down, some pitch near the poles, rest raw.
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end
        3, 4: begin
          // Near gimbal lock: w close to 1/sqrt(2), y close to plus or minus 1/sqrt(2).
          ang = $urandom_range(0, 60);
          q.qw = 16'(11585 - 30 + ang);
          q.qy = 16'(11585 - $urandom_range(0, 60));
          if ($urandom_range(0, 1)) q.qy = -q.qy;
          q.qx = 16'($signed($urandom_range(0, 200)) - 100);
          q.qz = 16'($signed($urandom_range(0, 200)) - 100);
        end
        default: begin
          th = $urandom_range(0, 65535) / 65536.0;
          q.qx = 16'($signed($urandom_range(0, 32767)) - 16384);
          q.qy = 16'($signed($urandom_range(0, 32767)) - 16384);
          q.qz = 16'($signed($urandom_range(0, 32767)) - 16384);
          q.qw = 16'(int'(16384.0 * (2.0 * th - 1.0)));
          ang = $urandom_range(1, 3);
          q.qx = q.qx >>> ang;
          q.qy = q.qy >>> ang;
          q.qz = q.qz >>> ang;
        end
      endcase
      pending_quats.push_back(q);
    end
    stim_done = 1'b1;
  end

  initial stim_done = 1'b0;

  // Driver: offers the next quaternion, idling at random after the first stretch.
  int drv_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.quat_x <= '0;
      in_ch.quat_y <= '0;
      in_ch.quat_z <= '0;
      in_ch.quat_w <= '0;
      drv_count <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_angles.push_back(euler_of('{in_ch.quat_x, in_ch.quat_y,
                                             in_ch.quat_z, in_ch.quat_w}));
        drv_count <= drv_count + 1;
      end
      if (pending_quats.size() != 0 &&
          (drv_count < 300 || $urandom_range(0, 99) >= 38)) begin
        quat_t q;
        q = pending_quats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.quat_x <= q.qx;
        in_ch.quat_y <= q.qy;
        in_ch.quat_z <= q.qz;
        in_ch.quat_w <= q.qw;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process, so the pipeline fills.
  initial begin
    hold_on = 1'b0;
    wait (drv_count > 500);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (200) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver ready, with random stalls outside the first stretch.
  int mon_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_on && (mon_count < 300 || $urandom_range(0, 99) >= 38);
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    euler_t e;
    if (!rst_n) begin
      mon_count <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      mon_count <= mon_count + 1;
      if (expected_angles.size() == 0) begin
        $error("result transaction with no expected result");
        failed = 1'b1;
      end else begin
        e = expected_angles.pop_front();
        if (out_ch.roll_angle !== e.roll) begin
          $error("roll_angle: expected %0d, actual %0d", e.roll, out_ch.roll_angle);
          failed = 1'b1;
        end
        if (out_ch.pitch_angle !== e.pitch) begin
          $error("pitch_angle: expected %0d, actual %0d", e.pitch, out_ch.pitch_angle);
          failed = 1'b1;
        end
        if (out_ch.yaw_angle !== e.yaw) begin
          $error("yaw_angle: expected %0d, actual %0d", e.yaw, out_ch.yaw_angle);
          failed = 1'b1;
        end
        if (out_ch.pitch_clamped !== e.clamped) begin
          $error("pitch_clamped: expected %0b, actual %0b", e.clamped,
                 out_ch.pitch_clamped);
          failed = 1'b1;
        end
      end
    end
  end

  // End of run: drain, settle, then report.
  initial begin
    failed = 1'b0;
    wait (stim_done);
    wait (pending_quats.size() == 0 && !in_ch.valid);
    wait (expected_angles.size() == 0);
    repeat (4 * LATENCY) @(posedge clk);
    if (expected_angles.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("quaternion_to_euler_angles_top regression: pass");
    end else begin
      $display("quaternion_to_euler_angles_top regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("quaternion_to_euler_angles_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
